### hdl/bsie_pkg.sv
// Shared types, constants and helper functions for the bit-sliced index encoder.
// Used by bsie_front, bsie_queue, bsie_back and the top level; depends on nothing.
package bsie_pkg;

    localparam int ROW_BITS       = 64;
    localparam int VALUE_BITS     = 32;
    localparam int NUM_WORDS      = VALUE_BITS + 2;
    localparam int COUNT_BITS     = 17;
    localparam int GROUP_BITS     = 10;
    localparam int NEED_BITS      = 6;
    localparam int ROW_IDX_BITS   = 6;
    localparam int SLICE_IDX_BITS = 5;
    localparam int WORD_CNT_BITS  = 6;

    localparam logic [COUNT_BITS-1:0]    COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [ROW_IDX_BITS-1:0]  ROW_LAST  = ROW_IDX_BITS'(ROW_BITS - 1);
    localparam logic [WORD_CNT_BITS-1:0] WORD_LAST = WORD_CNT_BITS'(NUM_WORDS - 1);

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SIGN  = 2'd0;
    localparam kind_t KIND_EXIST = 2'd1;
    localparam kind_t KIND_SLICE = 2'd2;

    // One closed group: word 0 is the sign word, word 1 the existence word,
    // word 2+i the magnitude slice i. Counts follow the same order.
    typedef struct packed {
        logic [NUM_WORDS-1:0][ROW_BITS-1:0]   words;
        logic [NUM_WORDS-1:0][COUNT_BITS-1:0] counts;
        logic [NEED_BITS-1:0]                 need;
        logic [GROUP_BITS-1:0]                group;
        logic                                 eos;
    } run_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
    endfunction

    function automatic logic [NEED_BITS-1:0] bit_len(input logic [VALUE_BITS-1:0] v);
        logic [NEED_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (v[i])
            begin
                n = NEED_BITS'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

### hdl/bit_slice_index_encoder_unit.sv
// Top level of the sign-magnitude bit-sliced index encoder.
// Instantiates bsie_front, bsie_queue and bsie_back; uses bsie_pkg.
//
// Input channel: item_valid / item_stall carry one signed value per word plus a
// last flag that ends the data set. Output channel: result_valid / result_stall
// carry result words. A word moves when valid is high and stall is low.
// Every 64 rows, or at a row marked last, the block emits a run of 34 result
// words: the sign word, the existence word, then magnitude slices 0 to 31.
// The first word of a run becomes valid once the closing row has passed through the
// queue register and been loaded into the back-end shift register. The run then
// leaves at one word per cycle while the receiver does not stall.
// Rows are taken at one per cycle. A row that closes a group is held off while
// the single queue slot is occupied: for the cycle right after a run was queued,
// and for as long as the back end is still shifting out an earlier run.
// Reset clears all accumulators, counters and the queue; no results are pending.
// A receiver stall only pauses the back end; the front keeps taking rows until
// it has a group to close and the queue slot is still occupied.
module bit_slice_index_encoder_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic signed [bsie_pkg::VALUE_BITS-1:0] value,
    input  logic                                   last,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [1:0]                             kind,
    output logic [bsie_pkg::SLICE_IDX_BITS-1:0]    slice_index,
    output logic [bsie_pkg::GROUP_BITS-1:0]        word_index,
    output logic [bsie_pkg::ROW_BITS-1:0]          bits_word,
    output logic [bsie_pkg::COUNT_BITS-1:0]        ones_count,
    output logic [bsie_pkg::NEED_BITS-1:0]         slices_needed,
    output logic                                   last_of_run,
    output logic                                   end_of_stream
);

    logic           push, pop, q_full;
    bsie_pkg::run_t push_run, pop_run;
    bsie_pkg::kind_t kind_w;

    bsie_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .last       (last),
        .q_full     (q_full),
        .push       (push),
        .push_run   (push_run)
    );

    bsie_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .full     (q_full),
        .pop_run  (pop_run)
    );

    bsie_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_full        (q_full),
        .q_run         (pop_run),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind_w),
        .slice_index   (slice_index),
        .word_index    (word_index),
        .bits_word     (bits_word),
        .ones_count    (ones_count),
        .slices_needed (slices_needed),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream)
    );

    assign kind = kind_w;

endmodule

### hdl/bsie_front.sv
// Front end: accepts values, builds the sign, existence and slice words of the
// current group, and hands a closed group to the queue. Uses bsie_pkg.
module bsie_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [bsie_pkg::VALUE_BITS-1:0] value,
    input  logic                              last,
    input  logic                              q_full,
    output logic                              push,
    output bsie_pkg::run_t                    push_run
);

    logic [bsie_pkg::ROW_BITS-1:0]   sign_reg, sign_next, sign_upd;
    logic [bsie_pkg::ROW_BITS-1:0]   exist_reg, exist_next, exist_upd;
    logic [bsie_pkg::VALUE_BITS-1:0][bsie_pkg::ROW_BITS-1:0] slice_reg, slice_next, slice_upd;
    logic [bsie_pkg::COUNT_BITS-1:0] sign_cnt_reg, sign_cnt_next, sign_cnt_upd;
    logic [bsie_pkg::COUNT_BITS-1:0] exist_cnt_reg, exist_cnt_next, exist_cnt_upd;
    logic [bsie_pkg::VALUE_BITS-1:0][bsie_pkg::COUNT_BITS-1:0] slice_cnt_reg, slice_cnt_next;
    logic [bsie_pkg::VALUE_BITS-1:0][bsie_pkg::COUNT_BITS-1:0] slice_cnt_upd;
    logic [bsie_pkg::ROW_IDX_BITS-1:0] row_reg, row_next;
    logic [bsie_pkg::GROUP_BITS-1:0]   group_reg, group_next;
    logic [bsie_pkg::NEED_BITS-1:0]    need_reg, need_next, need_upd, need_item;

    logic [bsie_pkg::VALUE_BITS-1:0] value_u, mag;
    logic [bsie_pkg::ROW_BITS-1:0]   row_mask;
    logic                            neg, accept, close;

    // A closing row needs the queue slot; other rows never wait.
    assign item_stall = q_full && item_valid && (last || row_reg == bsie_pkg::ROW_LAST);
    assign accept     = item_valid && !item_stall;
    assign close      = accept && (last || row_reg == bsie_pkg::ROW_LAST);

    always_comb
    begin
        value_u   = unsigned'(value);
        neg       = value_u[bsie_pkg::VALUE_BITS-1];
        mag       = neg ? (~value_u + bsie_pkg::VALUE_BITS'(1)) : value_u;
        row_mask  = bsie_pkg::ROW_BITS'(1) << row_reg;
        sign_upd  = neg ? (sign_reg | row_mask) : sign_reg;
        sign_cnt_upd  = neg ? bsie_pkg::sat_inc(sign_cnt_reg) : sign_cnt_reg;
        exist_upd     = (mag != '0) ? (exist_reg | row_mask) : exist_reg;
        exist_cnt_upd = (mag != '0) ? bsie_pkg::sat_inc(exist_cnt_reg) : exist_cnt_reg;
        for (int i = 0; i < bsie_pkg::VALUE_BITS; i++)
        begin
            slice_upd[i]     = mag[i] ? (slice_reg[i] | row_mask) : slice_reg[i];
            slice_cnt_upd[i] = mag[i] ? bsie_pkg::sat_inc(slice_cnt_reg[i]) : slice_cnt_reg[i];
        end
        need_item = bsie_pkg::bit_len(mag);
        need_upd  = (need_item > need_reg) ? need_item : need_reg;
    end

    always_comb
    begin
        push_run.words[0]  = sign_upd;
        push_run.words[1]  = exist_upd;
        push_run.counts[0] = sign_cnt_upd;
        push_run.counts[1] = exist_cnt_upd;
        for (int i = 0; i < bsie_pkg::VALUE_BITS; i++)
        begin
            push_run.words[i+2]  = slice_upd[i];
            push_run.counts[i+2] = slice_cnt_upd[i];
        end
        push_run.need  = need_upd;
        push_run.group = group_reg;
        push_run.eos   = last;
        push           = close;
    end

    always_comb
    begin
        sign_next      = sign_reg;
        exist_next     = exist_reg;
        slice_next     = slice_reg;
        sign_cnt_next  = sign_cnt_reg;
        exist_cnt_next = exist_cnt_reg;
        slice_cnt_next = slice_cnt_reg;
        row_next       = row_reg;
        group_next     = group_reg;
        need_next      = need_reg;
        if (close)
        begin
            sign_next  = '0;
            exist_next = '0;
            slice_next = '0;
            row_next   = '0;
            if (last)
            begin
                sign_cnt_next  = '0;
                exist_cnt_next = '0;
                slice_cnt_next = '0;
                group_next     = '0;
                need_next      = '0;
            end
            else
            begin
                sign_cnt_next  = sign_cnt_upd;
                exist_cnt_next = exist_cnt_upd;
                slice_cnt_next = slice_cnt_upd;
                group_next     = group_reg + bsie_pkg::GROUP_BITS'(1);
                need_next      = need_upd;
            end
        end
        else if (accept)
        begin
            sign_next      = sign_upd;
            exist_next     = exist_upd;
            slice_next     = slice_upd;
            sign_cnt_next  = sign_cnt_upd;
            exist_cnt_next = exist_cnt_upd;
            slice_cnt_next = slice_cnt_upd;
            row_next       = row_reg + bsie_pkg::ROW_IDX_BITS'(1);
            need_next      = need_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg      <= '0;
            exist_reg     <= '0;
            slice_reg     <= '0;
            sign_cnt_reg  <= '0;
            exist_cnt_reg <= '0;
            slice_cnt_reg <= '0;
            row_reg       <= '0;
            group_reg     <= '0;
            need_reg      <= '0;
        end
        else
        begin
            sign_reg      <= sign_next;
            exist_reg     <= exist_next;
            slice_reg     <= slice_next;
            sign_cnt_reg  <= sign_cnt_next;
            exist_cnt_reg <= exist_cnt_next;
            slice_cnt_reg <= slice_cnt_next;
            row_reg       <= row_next;
            group_reg     <= group_next;
            need_reg      <= need_next;
        end
    end

endmodule

### hdl/bsie_queue.sv
// Single-entry queue that holds one closed group between the front and back ends.
// Uses bsie_pkg for the run_t record.
module bsie_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsie_pkg::run_t push_run,
    input  logic           pop,
    output logic           full,
    output bsie_pkg::run_t pop_run
);

    logic           full_reg, full_next;
    bsie_pkg::run_t data_reg, data_next;

    always_comb
    begin
        full_next = full_reg;
        data_next = data_reg;
        if (push)
        begin
            full_next = 1'b1;
            data_next = push_run;
        end
        else if (pop)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign full    = full_reg;
    assign pop_run = data_reg;

endmodule

### hdl/bsie_back.sv
// Back end: takes a closed group from the queue and shifts out its 34 words,
// one per accepted result word. Uses bsie_pkg.
module bsie_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_full,
    input  bsie_pkg::run_t                        q_run,
    output logic                                  pop,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output bsie_pkg::kind_t                       kind,
    output logic [bsie_pkg::SLICE_IDX_BITS-1:0]   slice_index,
    output logic [bsie_pkg::GROUP_BITS-1:0]       word_index,
    output logic [bsie_pkg::ROW_BITS-1:0]         bits_word,
    output logic [bsie_pkg::COUNT_BITS-1:0]       ones_count,
    output logic [bsie_pkg::NEED_BITS-1:0]        slices_needed,
    output logic                                  last_of_run,
    output logic                                  end_of_stream
);

    logic                               busy_reg, busy_next;
    logic [bsie_pkg::WORD_CNT_BITS-1:0] cnt_reg, cnt_next, slice_tmp;
    bsie_pkg::run_t                     run_reg, run_next;
    logic                               take, done, load;

    assign take = busy_reg && !result_stall;
    assign done = take && (cnt_reg == bsie_pkg::WORD_LAST);
    assign load = q_full && (!busy_reg || done);
    assign pop  = load;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            run_next  = q_run;
        end
        else if (take)
        begin
            // The word on the output always sits in entry 0 of the shift register.
            run_next.words  = run_reg.words >> bsie_pkg::ROW_BITS;
            run_next.counts = run_reg.counts >> bsie_pkg::COUNT_BITS;
            cnt_next        = cnt_reg + bsie_pkg::WORD_CNT_BITS'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

    always_comb
    begin
        slice_tmp = cnt_reg - bsie_pkg::WORD_CNT_BITS'(2);
        case (cnt_reg)
            bsie_pkg::WORD_CNT_BITS'(0):
            begin
                kind        = bsie_pkg::KIND_SIGN;
                slice_index = '0;
            end
            bsie_pkg::WORD_CNT_BITS'(1):
            begin
                kind        = bsie_pkg::KIND_EXIST;
                slice_index = '0;
            end
            default:
            begin
                kind        = bsie_pkg::KIND_SLICE;
                slice_index = slice_tmp[bsie_pkg::SLICE_IDX_BITS-1:0];
            end
        endcase
    end

    assign result_valid  = busy_reg;
    assign word_index    = run_reg.group;
    assign bits_word     = run_reg.words[0];
    assign ones_count    = run_reg.counts[0];
    assign slices_needed = run_reg.need;
    assign last_of_run   = (cnt_reg == bsie_pkg::WORD_LAST);
    assign end_of_stream = run_reg.eos;

endmodule
